[rtl/erd_pkg.sv]
package erd_pkg;

   // input actions
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_PUSH  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_TICK  = 2'd3;

   // event types
   localparam logic [3:0] EVT_THR_HIGH  = 4'd4;
   localparam logic [3:0] EVT_THR_LOW   = 4'd5;
   localparam logic [3:0] EVT_UNDERVOLT = 4'd6;
   localparam logic [3:0] EVT_OVERVOLT  = 4'd7;
   localparam logic [3:0] EVT_OVERTEMP  = 4'd8;

   // rule action kinds
   localparam logic [2:0] AK_WRITE   = 3'd0;
   localparam logic [2:0] AK_SET_OUT = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_FIRED    = 2'd0;
   localparam logic [1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [1:0] KIND_DROPPED  = 2'd2;

   localparam int MAX_RESULTS = 64;
   localparam int NW = 7;   // result counter width, holds MAX_RESULTS

   typedef struct packed {
      logic [1:0]         action;
      logic [2:0]         slot;
      logic               rule_valid;
      logic               rule_enabled;
      logic [3:0]         event_type;
      logic [5:0]         channel;
      logic [5:0]         guard_channel;
      logic [5:0]         dest_channel;
      logic [2:0]         action_kind;
      logic signed [31:0] data_value;
      logic signed [31:0] threshold;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         fired_slot;
      logic [2:0]         fired_action;
      logic [5:0]         fired_target;
      logic signed [31:0] fired_value;
      logic               target_usable;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         evt;
      logic [5:0]         src;
      logic [5:0]         cond;
      logic [5:0]         tgt;
      logic [2:0]         act;
      logic signed [31:0] val;
      logic signed [31:0] thr;
   } rule_type;

   typedef struct packed {
      logic [3:0]         evt;
      logic [5:0]         src;
      logic signed [31:0] val;
   } queue_entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EVAL,
      S_POP,
      S_MATCH_RD,
      S_MATCH_EVAL,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic exec;        // item accepted this cycle
      logic idx_clr;
      logic match_rd;    // channel read uses condition channel
      logic scan_eval;
      logic pop;
      logic match_eval;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic q_empty;
   } status_type;

endpackage

[rtl/erd_ctrl.sv]
module erd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          action,
   input  erd_pkg::status_type status,
   output erd_pkg::cmd_type    cmd,
   output logic                busy
);
   import erd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.exec = 1'b1;
               if (action == ACT_TICK) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_EVAL;
         end
         S_SCAN_EVAL: begin
            cmd.scan_eval = 1'b1;
            state_in      = status.idx_last ? S_POP : S_SCAN_RD;
         end
         S_POP: begin
            if (status.q_empty) begin
               state_in = S_FLUSH;
            end else begin
               cmd.pop     = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_MATCH_RD;
            end
         end
         S_MATCH_RD: begin
            cmd.match_rd = 1'b1;
            state_in     = S_MATCH_EVAL;
         end
         S_MATCH_EVAL: begin
            cmd.match_eval = 1'b1;
            state_in       = status.idx_last ? S_POP : S_MATCH_RD;
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[rtl/erd_datapath.sv]
module erd_datapath #(
   parameter int RULE_SLOTS    = 8,
   parameter int QUEUE_DEPTH   = 8,
   parameter int CHANNEL_COUNT = 64,
   parameter int OUTPUT_COUNT  = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  erd_pkg::req_type    req,
   input  erd_pkg::cmd_type    cmd,
   output erd_pkg::status_type status,
   output logic                rsp_strobe,
   output erd_pkg::rsp_type    rsp_data
);
   import erd_pkg::*;

   localparam int RW  = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int CW  = $clog2(CHANNEL_COUNT);

   // rule table
   logic [RULE_SLOTS-1:0] rule_vld_ff, rule_en_ff, above_ff;
   rule_type              rules_ff [RULE_SLOTS];
   logic [RW-1:0]         idx_ff, idx_in;
   rule_type              cur;
   logic                  cur_vld;

   // event queue
   queue_entry_type       queue_ff [QUEUE_DEPTH];
   logic [QW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [QCW-1:0]        count_ff, count_in;
   queue_entry_type       evt_ff, push_entry;
   logic                  q_full, req_push, scan_push, do_push;

   // channel store
   logic signed [31:0]    chan_mem [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0] chan_vld_ff;
   logic signed [31:0]    rd_data_ff, rd_val;
   logic                  rd_ok_ff;
   logic [5:0]            rd_ch;
   logic [CW-1:0]         rd_addr, wr_addr;
   logic                  rd_in_range, wr_en;

   // evaluation
   logic                  load_en, scan_act, above, rise, fall;
   logic                  sys_evt, match, cond_ok, fire;
   logic [NW-1:0]         n_ff, n_in;
   rsp_type               fired, pend_ff, pend_in, rsp_ff, rsp_in;
   logic                  pend_vld_ff, pend_vld_in, rsp_vld_ff, rsp_vld_in;

   assign cur     = rules_ff[idx_ff];
   assign cur_vld = rule_vld_ff[idx_ff] && rule_en_ff[idx_ff];

   assign load_en = cmd.exec && (req.action == ACT_LOAD)
                    && (7'(req.slot) < 7'(RULE_SLOTS));

   // channel store: one write port (idle only), one registered read port
   assign rd_ch       = cmd.match_rd ? cur.cond : cur.src;
   assign rd_in_range = 9'(rd_ch) < 9'(CHANNEL_COUNT);
   assign rd_addr     = CW'(rd_ch);
   assign wr_addr     = CW'(req.channel);
   assign wr_en       = cmd.exec && (req.action == ACT_WRITE)
                        && (9'(req.channel) < 9'(CHANNEL_COUNT));
   assign rd_val      = rd_ok_ff ? rd_data_ff : 32'sd0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         chan_mem[wr_addr] <= req.data_value;
      end
      rd_data_ff <= chan_mem[rd_addr];
      rd_ok_ff   <= rd_in_range && chan_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_vld_ff <= '0;
      end else if (wr_en) begin
         chan_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // threshold scan
   assign scan_act = cmd.scan_eval && cur_vld && (cur.src != 6'd0)
                     && ((cur.evt == EVT_THR_HIGH) || (cur.evt == EVT_THR_LOW));
   assign above    = rd_val >= cur.thr;
   assign rise     = (cur.evt == EVT_THR_HIGH) && !above_ff[idx_ff] && above;
   assign fall     = (cur.evt == EVT_THR_LOW) && above_ff[idx_ff] && !above;
   assign scan_push = scan_act && (rise || fall);

   // queue
   assign req_push = cmd.exec && (req.action == ACT_PUSH);
   assign q_full   = (count_ff == QCW'(QUEUE_DEPTH));
   assign do_push  = (req_push || scan_push) && !q_full;

   always_comb begin
      if (req_push) begin
         push_entry = '{evt: req.event_type, src: req.channel, val: req.data_value};
      end else begin
         push_entry = '{evt: cur.evt, src: cur.src, val: rd_val};
      end
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         head_in  = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         tail_in  = (tail_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[head_ff] <= push_entry;
      end
      if (cmd.pop) begin
         evt_ff <= queue_ff[tail_ff];
      end
      if (load_en) begin
         rules_ff[RW'(req.slot)] <= '{evt: req.event_type, src: req.channel,
                                      cond: req.guard_channel,
                                      tgt: req.dest_channel, act: req.action_kind,
                                      val: req.data_value, thr: req.threshold};
      end
   end

   // rule matching
   always_comb begin
      sys_evt = evt_ff.evt inside {EVT_UNDERVOLT, EVT_OVERVOLT, EVT_OVERTEMP};
      match   = (cur.evt == evt_ff.evt)
                && (sys_evt || ((cur.src != 6'd0) && (cur.src == evt_ff.src)));
      cond_ok = (cur.cond == 6'd0) || (rd_val != 32'sd0);
      fire    = cmd.match_eval && cur_vld && match && cond_ok
                && (n_ff < NW'(MAX_RESULTS));

      fired               = '0;
      fired.kind          = KIND_FIRED;
      fired.fired_slot    = 3'(idx_ff);
      fired.fired_action  = cur.act;
      fired.fired_target  = cur.tgt;
      fired.fired_value   = cur.val;
      case (cur.act)
         AK_WRITE: begin
            fired.target_usable = (cur.tgt != 6'd0);
         end
         AK_SET_OUT: begin
            fired.fired_value   = (cur.val != 32'sd0) ? 32'sd1 : 32'sd0;
            fired.target_usable = (cur.tgt != 6'd0)
                                  && (7'(cur.tgt) < 7'(OUTPUT_COUNT));
         end
         default: begin
            fired.target_usable = 1'b0;
         end
      endcase
   end

   // one result held back so the last one of a tick can be marked
   always_comb begin
      idx_in      = idx_ff;
      n_in        = n_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = 1'b0;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.scan_eval || cmd.match_eval) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.exec) begin
         n_in = '0;
      end else if (fire) begin
         n_in = n_ff + 1'b1;
      end
      if (req_push) begin
         rsp_vld_in  = 1'b1;
         rsp_in      = '0;
         rsp_in.kind = q_full ? KIND_DROPPED : KIND_ACCEPTED;
         rsp_in.last = 1'b1;
      end else if (fire) begin
         rsp_vld_in  = pend_vld_ff;
         rsp_in      = pend_ff;
         pend_in     = fired;
         pend_vld_in = 1'b1;
      end else if (cmd.flush) begin
         rsp_vld_in  = pend_vld_ff;
         rsp_in      = pend_ff;
         rsp_in.last = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      idx_ff  <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_vld_ff <= '0;
         rule_en_ff  <= '0;
         above_ff    <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         n_ff        <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (load_en) begin
            rule_vld_ff[RW'(req.slot)] <= req.rule_valid;
            rule_en_ff[RW'(req.slot)]  <= req.rule_enabled;
            above_ff[RW'(req.slot)]    <= 1'b0;
         end else if (scan_act) begin
            above_ff[idx_ff] <= above;
         end
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         n_ff        <= n_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   assign status.idx_last = (idx_ff == RW'(RULE_SLOTS - 1));
   assign status.q_empty  = (count_ff == '0);
   assign rsp_strobe      = rsp_vld_ff;
   assign rsp_data        = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with pointers apart");
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush && pend_vld_ff |=> rsp_vld_ff && rsp_ff.last)
      else $error("held result not sent as last");
   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(MAX_RESULTS))
      else $error("result count above cap");
`endif

endmodule

[rtl/event_rule_dispatcher.sv]
// Loads, channel writes and pushes leave the block idle; a push result strobes the next cycle.
// An update tick runs the threshold scan over all rule slots, then a match pass over all
// slots per queued event, then a flush to finish; busy is high throughout.
// Every rule visit is a registered read of the channel store followed by an evaluate.
// Results leave one per strobe cycle; the receiver cannot stall them.
// Synchronous active-high reset clears rules, queue and the channel store.
module event_rule_dispatcher #(
   parameter int RULE_SLOTS    = 8,
   parameter int QUEUE_DEPTH   = 8,
   parameter int CHANNEL_COUNT = 64,
   parameter int OUTPUT_COUNT  = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  erd_pkg::req_type req_data,
   output logic             rsp_strobe,
   output erd_pkg::rsp_type rsp_data
);
   import erd_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: scan rules, then drain the event queue rule by rule
   erd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // rule table, event queue, channel store and result register;
   // the last fired rule is held one step so the final transfer carries last
   erd_datapath #(
      .RULE_SLOTS    (RULE_SLOTS),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .OUTPUT_COUNT  (OUTPUT_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[verif/event_rule_dispatcher_test.sv]
`timescale 1ns / 1ps

module event_rule_dispatcher_test;
   import erd_pkg::*;

   localparam int SLOTS      = 8;
   localparam int QDEPTH     = 8;
   localparam int CHANNELS   = 64;
   localparam int OUTPUTS    = 30;
   localparam int RANDOM_ITEMS = 74;
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   event_rule_dispatcher dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // shadow copy of the block state
   logic               shadow_valid [SLOTS];
   logic               shadow_enable [SLOTS];
   rule_type           shadow_rule [SLOTS];
   logic               shadow_above [SLOTS];
   queue_entry_type    shadow_queue [$];
   logic signed [31:0] shadow_chan [CHANNELS];

   rsp_type pending_rsp [$];
   int      error_count;
   int      rsp_count;
   int      fired_count;
   int      dropped_count;
   int      item_count;
   longint  cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // result checker: every strobe is one transfer
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_type want;
         rsp_count++;
         if (rsp_data.kind == KIND_FIRED) fired_count++;
         if (rsp_data.kind == KIND_DROPPED) dropped_count++;
         if (pending_rsp.size() == 0) begin
            $display("%t unexpected result: actual %h", $realtime, rsp_data);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data !== want) begin
               $display("%t mismatch: expected kind %0d slot %0d act %0d tgt %0d val %0d use %0d last %0d",
                        $realtime, want.kind, want.fired_slot, want.fired_action,
                        want.fired_target, want.fired_value, want.target_usable, want.last);
               $display("%t           actual kind %0d slot %0d act %0d tgt %0d val %0d use %0d last %0d",
                        $realtime, rsp_data.kind, rsp_data.fired_slot, rsp_data.fired_action,
                        rsp_data.fired_target, rsp_data.fired_value, rsp_data.target_usable,
                        rsp_data.last);
               error_count++;
            end
         end
      end
   end

   function automatic logic signed [31:0] chan_value(logic [5:0] ch);
      return (ch < CHANNELS) ? shadow_chan[ch] : 32'sd0;
   endfunction

   function automatic logic queue_event(logic [3:0] evt, logic [5:0] src,
                                        logic signed [31:0] val);
      queue_entry_type e;
      if (shadow_queue.size() >= QDEPTH) return 1'b0;
      e.evt = evt;
      e.src = src;
      e.val = val;
      shadow_queue.push_back(e);
      return 1'b1;
   endfunction

   function automatic logic rule_hits(rule_type r, queue_entry_type e);
      if (r.evt != e.evt) return 1'b0;
      if (e.evt == EVT_UNDERVOLT || e.evt == EVT_OVERVOLT || e.evt == EVT_OVERTEMP)
         return 1'b1;
      return r.src != 0 && r.src == e.src;
   endfunction

   // works out the results of one accepted item and updates the shadow state
   task automatic dispatch_results(req_type it);
      rsp_type         r;
      rsp_type         fired [$];
      queue_entry_type e;
      logic signed [31:0] v;
      logic            above;
      case (it.action)
         ACT_LOAD: begin
            if (it.slot < SLOTS) begin
               shadow_valid[it.slot]  = it.rule_valid;
               shadow_enable[it.slot] = it.rule_enabled;
               shadow_rule[it.slot]   = '{evt: it.event_type, src: it.channel,
                                          cond: it.guard_channel,
                                          tgt: it.dest_channel, act: it.action_kind,
                                          val: it.data_value, thr: it.threshold};
               shadow_above[it.slot]  = 1'b0;
            end
         end
         ACT_PUSH: begin
            r = '0;
            r.kind = queue_event(it.event_type, it.channel, it.data_value)
                     ? KIND_ACCEPTED : KIND_DROPPED;
            r.last = 1'b1;
            pending_rsp.push_back(r);
         end
         ACT_WRITE: begin
            if (it.channel < CHANNELS) shadow_chan[it.channel] = it.data_value;
         end
         default: begin
            // threshold scan, slot order
            for (int i = 0; i < SLOTS; i++) begin
               if (!shadow_valid[i] || !shadow_enable[i]) continue;
               if (shadow_rule[i].evt != EVT_THR_HIGH && shadow_rule[i].evt != EVT_THR_LOW)
                  continue;
               if (shadow_rule[i].src == 0) continue;
               v = chan_value(shadow_rule[i].src);
               above = v >= shadow_rule[i].thr;
               if (shadow_rule[i].evt == EVT_THR_HIGH) begin
                  if (!shadow_above[i] && above)
                     void'(queue_event(EVT_THR_HIGH, shadow_rule[i].src, v));
               end else if (shadow_above[i] && !above) begin
                  void'(queue_event(EVT_THR_LOW, shadow_rule[i].src, v));
               end
               shadow_above[i] = above;
            end
            // drain
            while (shadow_queue.size() > 0) begin
               e = shadow_queue.pop_front();
               for (int i = 0; i < SLOTS; i++) begin
                  if (!shadow_valid[i] || !shadow_enable[i]) continue;
                  if (!rule_hits(shadow_rule[i], e)) continue;
                  if (shadow_rule[i].cond != 0 && chan_value(shadow_rule[i].cond) == 0)
                     continue;
                  if (fired.size() >= MAX_RESULTS) continue;
                  r = '0;
                  r.kind = KIND_FIRED;
                  r.fired_slot = i[2:0];
                  r.fired_action = shadow_rule[i].act;
                  r.fired_target = shadow_rule[i].tgt;
                  r.fired_value = shadow_rule[i].val;
                  if (shadow_rule[i].act == AK_WRITE) begin
                     r.target_usable = shadow_rule[i].tgt != 0;
                  end else if (shadow_rule[i].act == AK_SET_OUT) begin
                     r.fired_value = (shadow_rule[i].val != 0) ? 32'sd1 : 32'sd0;
                     r.target_usable = shadow_rule[i].tgt != 0 && shadow_rule[i].tgt < OUTPUTS;
                  end
                  fired.push_back(r);
               end
            end
            if (fired.size() > 0) fired[$].last = 1'b1;
            foreach (fired[k]) pending_rsp.push_back(fired[k]);
         end
      endcase
   endtask

   // one transfer: drive at the falling edge, accepted at the rising edge with busy low
   task automatic send_item(req_type it);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      dispatch_results(it);
      item_count++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
   endtask

   function automatic req_type make_rule(logic [2:0] slot, logic valid, logic en,
                                         logic [3:0] evt, logic [5:0] src,
                                         logic [5:0] cond, logic [5:0] tgt,
                                         logic [2:0] ak, logic signed [31:0] val,
                                         logic signed [31:0] thr);
      req_type it;
      it = '0;
      it.action = ACT_LOAD;
      it.slot = slot;
      it.rule_valid = valid;
      it.rule_enabled = en;
      it.event_type = evt;
      it.channel = src;
      it.guard_channel = cond;
      it.dest_channel = tgt;
      it.action_kind = ak;
      it.data_value = val;
      it.threshold = thr;
      return it;
   endfunction

   function automatic req_type make_simple(logic [1:0] act, logic [3:0] evt,
                                           logic [5:0] ch, logic signed [31:0] val);
      req_type it;
      it = '0;
      it.action = act;
      it.event_type = evt;
      it.channel = ch;
      it.data_value = val;
      return it;
   endfunction

   // random item biased toward small channel numbers so rules and events meet
   function automatic req_type random_item();
      req_type it;
      logic [5:0] ch_pick;
      int roll;
      it = '0;
      it.slot = 3'($urandom_range(0, 7));
      it.rule_valid = ($urandom_range(0, 9) != 0);
      it.rule_enabled = ($urandom_range(0, 7) != 0);
      it.event_type = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) != 0) it.event_type = 4'($urandom_range(0, 8));
      ch_pick = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
      it.channel = ch_pick;
      it.guard_channel = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 5)) : 6'd0;
      if ($urandom_range(0, 9) == 0) it.guard_channel = 6'($urandom);
      it.dest_channel = 6'($urandom);
      it.action_kind = 3'($urandom);
      it.data_value = ($urandom_range(0, 3) == 0) ? 32'($urandom)
                      : 32'($urandom_range(0, 20)) - 32'sd10;
      it.threshold = ($urandom_range(0, 5) == 0) ? 32'($urandom)
                     : 32'($urandom_range(0, 20)) - 32'sd10;
      roll = $urandom_range(0, 99);
      if (roll < 20) it.action = ACT_LOAD;
      else if (roll < 55) it.action = ACT_PUSH;
      else if (roll < 80) it.action = ACT_WRITE;
      else it.action = ACT_TICK;
      return it;
   endfunction

   req_type  directed_items [$];
   rsp_type  directed_want [$];
   logic     directed_has_want [$];

   task automatic add_row(req_type it, logic has_want, rsp_type want);
      directed_items.push_back(it);
      directed_has_want.push_back(has_want);
      directed_want.push_back(want);
   endtask

   initial begin
      rsp_type acc, full, none_rsp;
      int burst;
      int sent;
      cycle_count = 0;
      error_count = 0;
      rsp_count = 0;
      fired_count = 0;
      dropped_count = 0;
      item_count = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_enable[i] = 1'b0;
         shadow_rule[i] = '0;
         shadow_above[i] = 1'b0;
      end
      for (int i = 0; i < CHANNELS; i++) shadow_chan[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      acc = '0;  acc.kind = KIND_ACCEPTED;  acc.last = 1'b1;
      full = '0; full.kind = KIND_DROPPED;  full.last = 1'b1;
      none_rsp = '0;

      // directed table; a typed expectation is cross-checked against the predictor
      add_row(make_simple(ACT_TICK, 4'd0, 6'd0, 0), 1'b0, none_rsp);       // empty tick
      add_row(make_rule(3'd0, 1'b1, 1'b1, 4'd0, 6'd1, 6'd0, 6'd5, AK_WRITE,
                        32'sh7fffffff, 0), 1'b0, none_rsp);
      add_row(make_rule(3'd1, 1'b1, 1'b1, EVT_OVERTEMP, 6'd0, 6'd2, 6'd63, AK_SET_OUT,
                        32'sh80000000, 0), 1'b0, none_rsp);
      add_row(make_rule(3'd2, 1'b1, 1'b1, EVT_THR_HIGH, 6'd3, 6'd0, 6'd29, AK_SET_OUT,
                        0, 32'sd5), 1'b0, none_rsp);
      add_row(make_rule(3'd3, 1'b1, 1'b1, EVT_THR_LOW, 6'd3, 6'd0, 6'd0, 3'd7,
                        32'sd42, 32'sd5), 1'b0, none_rsp);
      add_row(make_rule(3'd7, 1'b1, 1'b0, 4'd0, 6'd1, 6'd0, 6'd1, 3'd1, 1, 0),
              1'b0, none_rsp);
      add_row(make_rule(3'd6, 1'b1, 1'b1, 4'd15, 6'd63, 6'd63, 6'd0, AK_WRITE,
                        -1, 32'sh80000000), 1'b0, none_rsp);
      add_row(make_simple(ACT_PUSH, 4'd0, 6'd1, 32'sd7), 1'b1, acc);
      add_row(make_simple(ACT_PUSH, EVT_OVERTEMP, 6'd9, 0), 1'b1, acc);    // cond 2 zero
      add_row(make_simple(ACT_PUSH, 4'd15, 6'd63, 0), 1'b1, acc);
      add_row(make_simple(ACT_TICK, 4'd0, 6'd0, 0), 1'b0, none_rsp);
      add_row(make_simple(ACT_WRITE, 4'd0, 6'd2, -1), 1'b0, none_rsp);     // cond passes
      add_row(make_simple(ACT_WRITE, 4'd0, 6'd3, 32'sd5), 1'b0, none_rsp); // rise
      add_row(make_simple(ACT_PUSH, EVT_OVERTEMP, 6'd0, 0), 1'b1, acc);
      add_row(make_simple(ACT_TICK, 4'd0, 6'd0, 0), 1'b0, none_rsp);
      add_row(make_simple(ACT_WRITE, 4'd0, 6'd3, 32'sd4), 1'b0, none_rsp); // fall
      add_row(make_simple(ACT_TICK, 4'd0, 6'd0, 0), 1'b0, none_rsp);
      for (int k = 0; k < QDEPTH; k++)
         add_row(make_simple(ACT_PUSH, EVT_OVERTEMP, 6'(k), 0), 1'b1, acc);
      add_row(make_simple(ACT_PUSH, 4'hf, 6'h3f, 32'sh80000000), 1'b1, full); // queue full
      add_row(make_simple(ACT_TICK, 4'd0, 6'd0, 0), 1'b0, none_rsp);

      foreach (directed_items[k]) begin
         send_item(directed_items[k]);
         if (directed_has_want[k] && pending_rsp[$] !== directed_want[k]) begin
            $display("%t table row %0d: expected %h, predicted %h", $realtime, k,
                     directed_want[k], pending_rsp[$]);
            error_count++;
         end
      end
      wait_drained();

      // fill rules to reach the 64-result cap exactly: 8 system rules x 8 events
      for (int s = 0; s < SLOTS; s++)
         send_item(make_rule(3'(s), 1'b1, 1'b1, EVT_UNDERVOLT, 6'd0, 6'd0, 6'(s), 3'(s),
                             s, 0));
      for (int k = 0; k < QDEPTH; k++)
         send_item(make_simple(ACT_PUSH, EVT_UNDERVOLT, 6'd0, 0));
      send_item(make_rule(3'd0, 1'b1, 1'b1, EVT_UNDERVOLT, 6'd0, 6'd0, 6'd1, AK_WRITE,
                          1, 0));
      send_item(make_simple(ACT_TICK, 4'd0, 6'd0, 0));
      wait_drained();

      // random part: bursts with gaps; one full drain pause midway
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            send_item(random_item());
            sent++;
            if (sent == RANDOM_ITEMS / 2) wait_drained();
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 25)) @(posedge clock);
      end
      send_item(make_simple(ACT_TICK, 4'd0, 6'd0, 0));
      wait_drained();
      repeat (40) @(posedge clock);

      $display("Sent %0d items; checked %0d results (%0d rule firings, %0d queue-full drops)",
               item_count, rsp_count, fired_count, dropped_count);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d errors, %0d results never arrived", error_count, pending_rsp.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
